// File: rtl/ttfs_pkg.sv
package ttfs_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIM_BITS   = 13;

    localparam logic signed [63:0] ONE_Q16   = 64'sd65536;
    localparam logic signed [63:0] TWO_Q16   = 64'sd131072;
    localparam logic signed [63:0] LIGHT_Q16 = 64'sd46341;
    localparam logic [16:0] RATIO_MIN = 17'd32768;
    localparam logic [16:0] RATIO_MAX = 17'd65536;

    localparam logic [1:0] CMD_LOAD_MVP = 2'd0;
    localparam logic [1:0] CMD_LOAD_ROT = 2'd1;
    localparam logic [1:0] CMD_VERTEX   = 2'd2;
    localparam logic [1:0] CMD_FACE     = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // job handed from the front to the back
    typedef struct packed {
        logic               is_face;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
    } t_job;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic [15:0]        shade_red;
        logic [15:0]        shade_green;
        logic [15:0]        shade_blue;
        logic signed [31:0] depth_sum;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROW,
        ST_POST,
        ST_SCALE,
        ST_OUT
    } t_state;

    function automatic logic signed [63:0] sat_coord(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// File: rtl/ttfs_stream_if.sv
interface ttfs_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ttfs_front.sv
module ttfs_front
    import ttfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_entry_index,
    input  logic [31:0] i_entry_value,
    input  t_job        i_job,
    input  logic        i_mvp_sel,
    input  logic [3:0]  i_rd_index,
    output logic [31:0] o_rd_data,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);
    logic [31:0] r_mvp [16];
    logic [31:0] r_rot [16];
    // two-entry job queue
    t_job        r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        is_load;
    logic        push;
    logic        pop;

    assign is_load = (i_command == CMD_LOAD_MVP) || (i_command == CMD_LOAD_ROT);
    // hold a load until no queued or running item can still read the stores
    assign o_ready = is_load ? ((r_cnt == 2'd0) && i_job_ready) : (r_cnt != 2'd2);
    assign push = i_valid && o_ready && !is_load;
    assign pop  = o_job_valid && i_job_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_command == CMD_LOAD_MVP) begin
            r_mvp[i_entry_index] <= i_entry_value;
        end
        if (i_valid && o_ready && i_command == CMD_LOAD_ROT) begin
            r_rot[i_entry_index] <= i_entry_value;
        end
        o_rd_data <= i_mvp_sel ? r_mvp[i_rd_index] : r_rot[i_rd_index];
        if (push) r_q[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: rtl/ttfs_back.sv
module ttfs_back
    import ttfs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  t_job          i_job,
    output logic          o_mvp_sel,
    output logic [3:0]    o_rd_index,
    input  logic [31:0]   i_rd_data,
    input  logic [DIM_BITS-1:0] i_width,
    input  logic [DIM_BITS-1:0] i_height,
    output logic          o_valid,
    input  logic          i_ready,
    output t_result       o_result
);
    t_state r_state, n_state;
    t_job   r_job;
    logic [1:0] r_row, r_col;
    logic [2:0] r_k;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_cx, r_cy, r_cz;
    logic [16:0] r_ratio;
    logic [1:0]  r_sc;
    logic signed [31:0] r_depth;
    t_result r_res;
    logic    r_out_v;
    logic signed [31:0] vec_el;

    assign o_mvp_sel = !r_job.is_face;
    assign o_rd_index = {r_row, r_col};
    assign o_job_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_v;
    assign o_result = r_res;

    always_comb begin
        case (r_k[1:0])
            2'd0: vec_el = r_job.vx;
            2'd1: vec_el = r_job.vy;
            2'd2: vec_el = r_job.vz;
            default: vec_el = 32'sd65536;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_job_valid) n_state = ST_MAC;
            ST_MAC:  n_state = ST_ROW;
            ST_ROW:  if (r_k == 3'd4) n_state = (r_row == 2'd2) ? ST_POST : ST_MAC;
            ST_POST: n_state = ST_SCALE;
            ST_SCALE: if (r_sc == 2'd3) n_state = ST_OUT;
            ST_OUT:  if (!r_out_v || i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ST_MAC primes the memory read; ST_ROW multiplies one entry a cycle
    always_ff @(posedge i_clk) begin
        logic signed [63:0] d;
        logic signed [63:0] cx1;
        t_result res_n;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
            r_depth <= 32'sd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_job <= i_job;
                    r_row <= i_job.is_face ? 2'd1 : 2'd0;
                    r_col <= 2'd0;
                    r_k <= 3'd0;
                end
                ST_MAC: begin
                    // column 0 is addressed now, column 1 next
                    r_col <= 2'd1;
                end
                ST_ROW: begin
                    // r_k counts entries; entry read at address issued last cycle
                    if (r_k < 3'd4) begin
                        r_prod <= $signed(i_rd_data) * 64'(vec_el);
                    end
                    if (r_k == 3'd4) begin
                        // advance to the next row
                        r_k <= 3'd0;
                        r_col <= 2'd0;
                        r_row <= r_row + 2'd1;
                    end else begin
                        r_k <= r_k + 3'd1;
                        r_col <= r_col + 2'd1;
                    end
                end
                default: ;
            endcase
            if (r_state == ST_SCALE) r_sc <= r_sc + 2'd1;
            if (r_state == ST_POST) r_sc <= 2'd0;
            if (r_state == ST_OUT && n_state == ST_IDLE) begin
                res_n = '0;
                res_n.kind = r_job.is_face;
                res_n.last = r_job.is_face;
                if (r_job.is_face) begin
                    res_n.shade_red   = 16'((33'(r_job.red) * 33'(r_ratio)) >> 16);
                    res_n.shade_green = 16'((33'(r_job.green) * 33'(r_ratio)) >> 16);
                    res_n.shade_blue  = 16'((33'(r_job.blue) * 33'(r_ratio)) >> 16);
                    res_n.depth_sum = r_depth;
                    r_depth <= 32'sd0;
                end else begin
                    cx1 = sat_coord(r_cx) + ONE_Q16;
                    res_n.screen_x = sat32((cx1 * $signed({51'd0, i_width})) >>> 1);
                    res_n.screen_y = sat32(((ONE_Q16 - sat_coord(r_cy))
                                     * $signed({51'd0, i_height})) >>> 1);
                    d = 64'(r_depth) + sat_coord(r_cz);
                    r_depth <= sat32(d);
                end
                r_res <= res_n;
                r_out_v <= 1'b1;
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // row accumulation, floor of each product
    always_ff @(posedge i_clk) begin
        logic signed [63:0] s;
        logic signed [63:0] diff;
        logic signed [63:0] rt;
        if (r_state == ST_IDLE) r_acc <= 64'sd0;
        if (r_state == ST_ROW && r_k != 3'd0) begin
            s = r_acc + (r_prod >>> 16);
            if (r_k == 3'd4) begin
                case (r_row)
                    2'd0: r_cx <= s;
                    2'd1: r_cy <= s;
                    default: r_cz <= s;
                endcase
                r_acc <= 64'sd0;
            end else r_acc <= s;
        end
        if (r_state == ST_POST) begin
            diff = sat_coord(r_cy) - sat_coord(r_cz);
            if (diff > TWO_Q16) diff = TWO_Q16;
            if (diff < -TWO_Q16) diff = -TWO_Q16;
            rt = (diff * LIGHT_Q16) >>> 16;
            if (rt < $signed({47'd0, RATIO_MIN})) r_ratio <= RATIO_MIN;
            else if (rt > $signed({47'd0, RATIO_MAX})) r_ratio <= RATIO_MAX;
            else r_ratio <= rt[16:0];
        end
    end
endmodule

// File: rtl/triangle_transform_flat_shade_core.sv
// Flat-shade geometry core.
// Input channel (ttfs_stream_if sink): command, entry index/value, vertex
// position, face normal and base color. Loads write the matrix stores and
// give no result. Vertex and face beats each give one result beat on the
// output channel (kind, screen x/y, shades, depth_sum, last).
// Configuration: write enable, index (0 width, 1 height), 13-bit data.
// A vertex or face is sent through one shared multiply-accumulate unit,
// one matrix entry a cycle: ST_MAC primes each row and ST_ROW takes its
// four entries, three rows for a vertex, two for a face, then the light
// state ST_POST, the scale state ST_SCALE and the output state ST_OUT.
// The back takes a new item only from idle, once the last item has left
// ST_OUT, which waits there while the output is stalled.
// A two-entry queue between the front and the back lets vertex and face
// beats go in while the back works or the output waits. A load is taken,
// one a cycle, only while the queue is empty and the back is idle.
// Reset clears control state, depth sum, and sets width 640 height 480.
// Matrix stores are undefined until loaded.
// When the receiver stalls, hold the result beat; the queue fills, then
// the input deasserts ready.
module triangle_transform_flat_shade_core
    import ttfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttfs_stream_if.sink   in_ch,
    ttfs_stream_if.source out_ch,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [DIM_BITS-1:0] i_cfg_data
);
    logic [DIM_BITS-1:0] r_width, r_height;
    logic        job_v, job_r, mvp_sel;
    t_job        job_in, job_q;
    logic [3:0]  rd_idx;
    logic [31:0] rd_data;
    t_result     res;

    // input payload layout: command, index, value, pos xyz, norm xyz, rgb
    logic [1:0]  cmd;
    logic [3:0]  eidx;
    logic [31:0] eval;
    assign cmd  = in_ch.data[277:276];
    assign eidx = in_ch.data[275:272];
    assign eval = in_ch.data[271:240];
    always_comb begin
        job_in.is_face = (cmd == CMD_FACE);
        job_in.vx = job_in.is_face ? in_ch.data[143:112] : in_ch.data[239:208];
        job_in.vy = job_in.is_face ? in_ch.data[111:80]  : in_ch.data[207:176];
        job_in.vz = job_in.is_face ? in_ch.data[79:48]   : in_ch.data[175:144];
        job_in.red   = in_ch.data[47:32];
        job_in.green = in_ch.data[31:16];
        job_in.blue  = in_ch.data[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 13'd640;
            r_height <= 13'd480;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_WIDTH) r_width <= i_cfg_data;
            else r_height <= i_cfg_data;
        end
    end

    ttfs_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_command(cmd), .i_entry_index(eidx), .i_entry_value(eval),
        .i_job(job_in), .i_mvp_sel(mvp_sel), .i_rd_index(rd_idx), .o_rd_data(rd_data),
        .o_job_valid(job_v), .i_job_ready(job_r), .o_job(job_q)
    );

    ttfs_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_v), .o_job_ready(job_r), .i_job(job_q),
        .o_mvp_sel(mvp_sel), .o_rd_index(rd_idx), .i_rd_data(rd_data),
        .i_width(r_width), .i_height(r_height),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_result(res)
    );

    assign out_ch.data = res;
endmodule
